>>> rtl/core/pfc_pkg.sv
package pfc_pkg;

    localparam int SQUARE_DIM   = 5;
    localparam int SQUARE_CELLS = 25;
    localparam int LETTER_COUNT = 26;

    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_CASE    = 8'h20;

    typedef enum logic [1:0] {
        FUNC_KEY_CHAR  = 2'd0,
        FUNC_KEY_END   = 2'd1,
        FUNC_TEXT_CHAR = 2'd2,
        FUNC_TEXT_END  = 2'd3
    } func_t;

    typedef struct packed {
        func_t      func;
        logic [4:0] letter;
        logic       is_letter;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_LOCATE,
        ST_EMIT_A,
        ST_EMIT_B
    } back_state_t;

    function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] step);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, step};
        if (s >= 4'(SQUARE_DIM))
        begin
            s = s - 4'(SQUARE_DIM);
        end
        return s[2:0];
    endfunction

    function automatic logic [4:0] cell_index(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

>>> rtl/core/pfc_front.sv
module pfc_front #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic [1:0]     s_tuser,
    output logic           q_valid,
    input  logic           q_ready,
    output pfc_pkg::item_t q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pfc_pkg::item_t queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [7:0]     upper;
    pfc_pkg::item_t item_in;
    logic           push;
    logic           pop;

    // fold case, map J onto I
    always_comb
    begin
        upper = s_tdata;
        if (s_tdata >= pfc_pkg::ASCII_LOWER_A && s_tdata <= pfc_pkg::ASCII_LOWER_Z)
        begin
            upper = s_tdata - pfc_pkg::ASCII_CASE;
        end
        item_in.func      = pfc_pkg::func_t'(s_tuser);
        item_in.is_letter = (upper >= pfc_pkg::ASCII_UPPER_A)
                            && (upper <= pfc_pkg::ASCII_UPPER_Z);
        item_in.letter    = 5'(upper - pfc_pkg::ASCII_UPPER_A);
        if (item_in.letter == pfc_pkg::LETTER_J)
        begin
            item_in.letter = pfc_pkg::LETTER_I;
        end
    end

    assign s_tready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = queue_mem[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> rtl/core/pfc_back.sv
module pfc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data,
    input  logic           q_valid,
    output logic           q_ready,
    input  pfc_pkg::item_t q_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,
    output logic           m_tlast,
    output logic           m_tuser
);

    logic [4:0] square_mem [pfc_pkg::SQUARE_CELLS];
    logic [5:0] pos_mem    [pfc_pkg::LETTER_COUNT];

    pfc_pkg::back_state_t state_reg, state_next;

    logic        mode_reg;
    logic [25:0] seen_reg, seen_next;
    logic [4:0]  fill_cnt_reg, fill_cnt_next;
    logic [2:0]  fill_row_reg, fill_row_next;
    logic [2:0]  fill_col_reg, fill_col_next;
    logic        ready_reg, ready_next;
    logic [4:0]  pend_reg, pend_next;
    logic        pend_vld_reg, pend_vld_next;
    logic [4:0]  sweep_reg, sweep_next;
    logic        end_reg, end_next;
    logic        m_valid_reg, m_valid_next;
    logic [6:0]  m_letter_reg, m_letter_next;
    logic        m_last_reg, m_last_next;
    logic        m_status_reg, m_status_next;

    logic [5:0]  pos_a_reg, pos_b_reg;
    logic [4:0]  cell_a_reg, cell_b_reg;

    logic        pop;
    logic        out_free;
    logic        place_req;
    logic        place_en;
    logic [4:0]  place_letter;
    logic        pos_rd_en;
    logic [4:0]  rd_b_letter;
    logic        sq_rd_en;
    logic [2:0]  ra, ca, rb, cb, step;
    logic [4:0]  idx_a, idx_b;

    assign out_free = !m_valid_reg || m_tready;
    assign q_ready  = (state_reg == pfc_pkg::ST_IDLE) && out_free;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    case (q_item.func)
                        pfc_pkg::FUNC_KEY_END:
                        begin
                            if (!ready_reg)
                            begin
                                state_next = pfc_pkg::ST_SWEEP;
                            end
                        end
                        pfc_pkg::FUNC_TEXT_CHAR:
                        begin
                            if (ready_reg && q_item.is_letter && pend_vld_reg)
                            begin
                                state_next = pfc_pkg::ST_LOCATE;
                            end
                        end
                        pfc_pkg::FUNC_TEXT_END:
                        begin
                            if (ready_reg && pend_vld_reg)
                            begin
                                state_next = pfc_pkg::ST_LOCATE;
                            end
                        end
                        default:
                        begin
                            state_next = pfc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            pfc_pkg::ST_SWEEP:
            begin
                if (sweep_reg == 5'(pfc_pkg::LETTER_COUNT - 1))
                begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            pfc_pkg::ST_LOCATE:
            begin
                state_next = pfc_pkg::ST_EMIT_A;
            end
            pfc_pkg::ST_EMIT_A:
            begin
                if (out_free)
                begin
                    state_next = pfc_pkg::ST_EMIT_B;
                end
            end
            pfc_pkg::ST_EMIT_B:
            begin
                if (out_free)
                begin
                    state_next = pfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ra    = pos_a_reg[5:3];
        ca    = pos_a_reg[2:0];
        rb    = pos_b_reg[5:3];
        cb    = pos_b_reg[2:0];
        step  = mode_reg ? 3'(pfc_pkg::SQUARE_DIM - 1) : 3'd1;
        if (ra == rb)
        begin
            idx_a = pfc_pkg::cell_index(ra, pfc_pkg::add_mod5(ca, step));
            idx_b = pfc_pkg::cell_index(rb, pfc_pkg::add_mod5(cb, step));
        end
        else if (ca == cb)
        begin
            idx_a = pfc_pkg::cell_index(pfc_pkg::add_mod5(ra, step), ca);
            idx_b = pfc_pkg::cell_index(pfc_pkg::add_mod5(rb, step), cb);
        end
        else
        begin
            idx_a = pfc_pkg::cell_index(ra, cb);
            idx_b = pfc_pkg::cell_index(rb, ca);
        end
    end

    always_comb
    begin
        place_req     = 1'b0;
        place_letter  = q_item.letter;
        pos_rd_en     = 1'b0;
        rd_b_letter   = q_item.letter;
        sq_rd_en      = 1'b0;
        ready_next    = ready_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        sweep_next    = sweep_reg;
        end_next      = end_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        m_letter_next = m_letter_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        case (state_reg)
            pfc_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    case (q_item.func)
                        pfc_pkg::FUNC_KEY_CHAR:
                        begin
                            place_req = !ready_reg && q_item.is_letter;
                        end
                        pfc_pkg::FUNC_KEY_END:
                        begin
                            sweep_next = '0;
                        end
                        default:
                        begin
                            if (!ready_reg)
                            begin
                                m_valid_next  = 1'b1;
                                m_letter_next = '0;
                                m_last_next   = (q_item.func == pfc_pkg::FUNC_TEXT_END);
                                m_status_next = 1'b1;
                            end
                            else if (q_item.func == pfc_pkg::FUNC_TEXT_CHAR)
                            begin
                                if (q_item.is_letter && !pend_vld_reg)
                                begin
                                    pend_next     = q_item.letter;
                                    pend_vld_next = 1'b1;
                                end
                                else if (q_item.is_letter)
                                begin
                                    pend_vld_next = 1'b0;
                                    pos_rd_en     = 1'b1;
                                    end_next      = 1'b0;
                                end
                            end
                            else if (pend_vld_reg)
                            begin
                                pend_vld_next = 1'b0;
                                pos_rd_en     = 1'b1;
                                rd_b_letter   = pfc_pkg::LETTER_X;
                                end_next      = 1'b1;
                            end
                        end
                    endcase
                end
            end
            pfc_pkg::ST_SWEEP:
            begin
                place_letter = sweep_reg;
                place_req    = (sweep_reg != pfc_pkg::LETTER_J);
                sweep_next   = sweep_reg + 1'b1;
                if (sweep_reg == 5'(pfc_pkg::LETTER_COUNT - 1))
                begin
                    ready_next = 1'b1;
                end
            end
            pfc_pkg::ST_LOCATE:
            begin
                sq_rd_en = 1'b1;
            end
            pfc_pkg::ST_EMIT_A:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_letter_next = pfc_pkg::ASCII_UPPER_A[6:0] + {2'b00, cell_a_reg};
                    m_last_next   = 1'b0;
                    m_status_next = 1'b0;
                end
            end
            pfc_pkg::ST_EMIT_B:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_letter_next = pfc_pkg::ASCII_UPPER_A[6:0] + {2'b00, cell_b_reg};
                    m_last_next   = end_reg;
                    m_status_next = 1'b0;
                end
            end
            default:
            begin
                place_req = 1'b0;
            end
        endcase
    end

    assign place_en = place_req && !seen_reg[place_letter]
                      && (fill_cnt_reg < 5'(pfc_pkg::SQUARE_CELLS));

    always_comb
    begin
        seen_next     = seen_reg;
        fill_cnt_next = fill_cnt_reg;
        fill_row_next = fill_row_reg;
        fill_col_next = fill_col_reg;
        if (place_en)
        begin
            seen_next     = seen_reg | (26'd1 << place_letter);
            fill_cnt_next = fill_cnt_reg + 1'b1;
            if (fill_col_reg == 3'(pfc_pkg::SQUARE_DIM - 1))
            begin
                fill_col_next = '0;
                fill_row_next = fill_row_reg + 1'b1;
            end
            else
            begin
                fill_col_next = fill_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pfc_pkg::ST_IDLE;
            mode_reg     <= 1'b0;
            seen_reg     <= '0;
            fill_cnt_reg <= '0;
            fill_row_reg <= '0;
            fill_col_reg <= '0;
            ready_reg    <= 1'b0;
            pend_reg     <= '0;
            pend_vld_reg <= 1'b0;
            sweep_reg    <= '0;
            end_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            seen_reg     <= seen_next;
            fill_cnt_reg <= fill_cnt_next;
            fill_row_reg <= fill_row_next;
            fill_col_reg <= fill_col_next;
            ready_reg    <= ready_next;
            pend_reg     <= pend_next;
            pend_vld_reg <= pend_vld_next;
            sweep_reg    <= sweep_next;
            end_reg      <= end_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_letter_reg <= m_letter_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (place_en)
        begin
            square_mem[fill_cnt_reg] <= place_letter;
            pos_mem[place_letter]    <= {fill_row_reg, fill_col_reg};
        end
        if (pos_rd_en)
        begin
            pos_a_reg <= pos_mem[pend_reg];
            pos_b_reg <= pos_mem[rd_b_letter];
        end
        if (sq_rd_en)
        begin
            cell_a_reg <= square_mem[idx_a];
            cell_b_reg <= square_mem[idx_b];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_letter_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_status_reg;

endmodule

>>> rtl/core/playfair_digram_cipher.sv
// channel | dir | handshake         | content
// s_*     | in  | s_tvalid/s_tready | tdata: char_byte; tuser: func
// m_*     | out | m_tvalid/m_tready | tdata: out_letter; tlast: last; tuser: status
// cfg_*   | in  | cfg_wr_en         | cfg_wr_data: decrypt_mode
//
// Key characters and unpaired letters are handled in the back end's idle
// state. A digram goes through a position read and a square read, then two
// result transfers from the output register. Key end runs a sweep of the
// alphabet to fill the square. Reset clears the control state; the square
// itself is written before first use. The input queue keeps accepting
// transfers, until it is full, while the back end stalls on m_tready.
module playfair_digram_cipher #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_byte
    input  logic [1:0] s_tuser,    // [1:0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [6:0] out_letter, [7] zero
    output logic       m_tlast,
    output logic       m_tuser,    // [0] status
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data
);

    logic           q_valid;
    logic           q_ready;
    pfc_pkg::item_t q_item;

    pfc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    pfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

>>> rtl/core/pfc_checker.sv
module pfc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 8'd0)
        else $error("error status with non-zero letter");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata >= 8'h41) && (m_tdata <= 8'h5A))
        else $error("result letter out of range");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind playfair_digram_cipher pfc_checker u_pfc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> bench/playfair_digram_cipher_checker.sv
`timescale 1ns / 100ps

module playfair_digram_cipher_checker
    import pfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] char_byte
    input  logic [1:0] s_tuser,    // [1:0] func
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,    // [6:0] out_letter, [7] zero
    input  logic       m_tlast,
    input  logic       m_tuser,    // [0] status
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    output int         fail_count,
    output int         outstanding,
    output int         checked_count
);

    typedef struct packed {
        logic [6:0] letter;
        logic       last;
        logic       status;
    } cipher_out_t;

    cipher_out_t             letters_due[$];
    cipher_out_t             due;
    logic [4:0]              square [SQUARE_CELLS];
    logic [LETTER_COUNT-1:0] used;
    int                      placed;
    logic                    square_done;
    logic [4:0]              held;
    logic                    held_valid;
    logic                    decrypt;
    int                      v;
    int                      n;

    function automatic int fold_letter(input logic [7:0] b);
        logic [7:0] c;
        int         idx;
        c = b;
        if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z)
        begin
            c = c - ASCII_CASE;
        end
        if (c < ASCII_UPPER_A || c > ASCII_UPPER_Z)
        begin
            return -1;
        end
        idx = int'(c) - int'(ASCII_UPPER_A);
        if (idx == int'(LETTER_J))
        begin
            idx = int'(LETTER_I);
        end
        return idx;
    endfunction

    function automatic void place_letter(input int idx);
        if (placed >= SQUARE_CELLS || used[idx])
        begin
            return;
        end
        used[idx]      = 1'b1;
        square[placed] = 5'(idx);
        placed++;
    endfunction

    function automatic int cell_of(input logic [4:0] letter);
        for (int k = 0; k < SQUARE_CELLS; k++)
        begin
            if (square[k] == letter)
            begin
                return k;
            end
        end
        return 0;
    endfunction

    function automatic logic [6:0] letter_at(input int r, input int c);
        int idx;
        idx = (r % SQUARE_DIM) * SQUARE_DIM + (c % SQUARE_DIM);
        return {2'b00, square[idx]} + ASCII_UPPER_A[6:0];
    endfunction

    function automatic void queue_letter(input logic [6:0] letter, input logic last,
                                         input logic status);
        cipher_out_t r;
        r.letter = letter;
        r.last   = last;
        r.status = status;
        letters_due.push_back(r);
    endfunction

    function automatic void encipher_pair(input logic [4:0] a, input logic [4:0] b,
                                          input logic at_end);
        int pa;
        int pb;
        int r1;
        int c1;
        int r2;
        int c2;
        int step;
        pa   = cell_of(a);
        pb   = cell_of(b);
        r1   = pa / SQUARE_DIM;
        c1   = pa % SQUARE_DIM;
        r2   = pb / SQUARE_DIM;
        c2   = pb % SQUARE_DIM;
        step = decrypt ? SQUARE_DIM - 1 : 1;
        if (r1 == r2)
        begin
            queue_letter(letter_at(r1, c1 + step), 1'b0, 1'b0);
            queue_letter(letter_at(r2, c2 + step), at_end, 1'b0);
        end
        else if (c1 == c2)
        begin
            queue_letter(letter_at(r1 + step, c1), 1'b0, 1'b0);
            queue_letter(letter_at(r2 + step, c2), at_end, 1'b0);
        end
        else
        begin
            queue_letter(letter_at(r1, c2), 1'b0, 1'b0);
            queue_letter(letter_at(r2, c1), at_end, 1'b0);
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            for (n = 0; n < SQUARE_CELLS; n++)
            begin
                square[n] = 5'd0;
            end
            used          = '0;
            placed        = 0;
            square_done   = 1'b0;
            held          = 5'd0;
            held_valid    = 1'b0;
            decrypt       = 1'b0;
            fail_count    = 0;
            checked_count = 0;
            letters_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (letters_due.size() == 0)
                begin
                    $error("unexpected transfer: out_letter %0d last %0b status %0b",
                           m_tdata[6:0], m_tlast, m_tuser);
                    fail_count++;
                end
                else
                begin
                    due = letters_due.pop_front();
                    checked_count++;
                    if (m_tdata[6:0] !== due.letter)
                    begin
                        $error("out_letter: expected %0d, got %0d", due.letter, m_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_tlast !== due.last)
                    begin
                        $error("last: expected %0b, got %0b", due.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tuser !== due.status)
                    begin
                        $error("status: expected %0b, got %0b", due.status, m_tuser);
                        fail_count++;
                    end
                end
            end

            if (cfg_wr_en)
            begin
                decrypt = cfg_wr_data;
            end

            if (s_tvalid && s_tready)
            begin
                case (s_tuser)
                    FUNC_KEY_CHAR:
                    begin
                        if (!square_done)
                        begin
                            v = fold_letter(s_tdata);
                            if (v >= 0)
                            begin
                                place_letter(v);
                            end
                        end
                    end
                    FUNC_KEY_END:
                    begin
                        if (!square_done)
                        begin
                            for (n = 0; n < LETTER_COUNT; n++)
                            begin
                                if (n != int'(LETTER_J))
                                begin
                                    place_letter(n);
                                end
                            end
                            square_done = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!square_done)
                        begin
                            queue_letter(7'd0, s_tuser == FUNC_TEXT_END, 1'b1);
                        end
                        else if (s_tuser == FUNC_TEXT_CHAR)
                        begin
                            v = fold_letter(s_tdata);
                            if (v >= 0)
                            begin
                                if (!held_valid)
                                begin
                                    held       = 5'(v);
                                    held_valid = 1'b1;
                                end
                                else
                                begin
                                    held_valid = 1'b0;
                                    encipher_pair(held, 5'(v), 1'b0);
                                end
                            end
                        end
                        else if (held_valid)
                        begin
                            held_valid = 1'b0;
                            encipher_pair(held, LETTER_X, 1'b1);
                        end
                    end
                endcase
            end
        end
        outstanding = letters_due.size();
    end

endmodule

>>> bench/playfair_digram_cipher_tb.sv
`timescale 1ns / 100ps

module playfair_digram_cipher_tb;

    localparam int SETTLE_CYCLES = 64;
    localparam int CHUNK_ITEMS   = 100;
    localparam int CHUNKS        = 6;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [1:0] s_tuser;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;
    logic       cfg_wr_en;
    logic       cfg_wr_data;

    int fail_count;
    int outstanding;
    int checked_count;
    int src_idle = 38;
    int snk_idle = 45;
    int transfers_in;
    int text_items;
    int pick;

    string key_text  = "PlAy~fJrEXm";
    string text_text = "pfPIPRjj[`az";

    playfair_digram_cipher dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    playfair_digram_cipher_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(1) ? pfc_pkg::ASCII_LOWER_A : pfc_pkg::ASCII_UPPER_A;
        return base + 8'($urandom_range(pfc_pkg::LETTER_COUNT - 1));
    endfunction

    // called and returns at a falling edge; tvalid stays high for the next transfer
    task automatic send_item(input pfc_pkg::func_t f, input logic [7:0] b);
        while ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        transfers_in++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        #5_000_000;
        $display("[playfair_digram_cipher] ERROR");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = 8'h00;
        s_tuser      = pfc_pkg::FUNC_KEY_CHAR;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 1'b0;
        transfers_in = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_mode(1'b0);

        // text while the square is still being built
        send_item(pfc_pkg::FUNC_TEXT_CHAR, "A");
        send_item(pfc_pkg::FUNC_TEXT_END, 8'h00);

        // fixed first two rows (PLAYF / IREXM), the rest of the key random
        for (int k = 0; k < key_text.len(); k++)
        begin
            send_item(pfc_pkg::FUNC_KEY_CHAR, key_text[k]);
        end
        send_item(pfc_pkg::FUNC_KEY_CHAR, 8'hFF);
        send_item(pfc_pkg::FUNC_KEY_CHAR, 8'h00);
        repeat ($urandom_range(12, 4))
        begin
            send_item(pfc_pkg::FUNC_KEY_CHAR, $urandom_range(3) != 0 ? any_letter()
                                                            : 8'($urandom_range(255)));
        end
        send_item(pfc_pkg::FUNC_KEY_END, 8'h00);
        send_item(pfc_pkg::FUNC_KEY_END, 8'hFF);
        send_item(pfc_pkg::FUNC_KEY_CHAR, "Z");

        // same row, same column, rectangle, double letter, drops, alphabet ends
        for (int k = 0; k < text_text.len(); k++)
        begin
            send_item(pfc_pkg::FUNC_TEXT_CHAR, text_text[k]);
        end
        send_item(pfc_pkg::FUNC_TEXT_CHAR, 8'h80);
        send_item(pfc_pkg::FUNC_TEXT_CHAR, "Z");
        send_item(pfc_pkg::FUNC_TEXT_END, 8'h00);
        send_item(pfc_pkg::FUNC_TEXT_END, 8'h00);

        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            settle();
            src_idle = (chunk < 2) ? 38 : (chunk < 4) ? 45 : 0;
            snk_idle = (chunk < 2) ? 45 : (chunk < 4) ? 38 : 0;
            write_mode(chunk % 2 == 0);
            text_items = 0;
            while (text_items < CHUNK_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 62)
                begin
                    send_item(pfc_pkg::FUNC_TEXT_CHAR, any_letter());
                    text_items++;
                end
                else if (pick < 74)
                begin
                    send_item(pfc_pkg::FUNC_TEXT_CHAR, 8'($urandom_range(255)));
                    text_items++;
                end
                else if (pick < 90)
                begin
                    send_item(pfc_pkg::FUNC_TEXT_END, 8'($urandom_range(255)));
                    text_items++;
                end
                else if (pick < 95)
                begin
                    send_item(pfc_pkg::FUNC_KEY_CHAR, 8'($urandom_range(255)));
                end
                else
                begin
                    send_item(pfc_pkg::FUNC_KEY_END, 8'($urandom_range(255)));
                end
            end
        end

        settle();
        $display("input transfers: %0d, result transfers checked: %0d", transfers_in,
                 checked_count);
        $display("covered early text, key build and fill, both modes, three idle patterns");
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("[playfair_digram_cipher] OK");
        end
        else
        begin
            $display("[playfair_digram_cipher] ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/pfc_pkg.sv
rtl/core/pfc_front.sv
rtl/core/pfc_back.sv
rtl/core/playfair_digram_cipher.sv
rtl/core/pfc_checker.sv
bench/playfair_digram_cipher_checker.sv
bench/playfair_digram_cipher_tb.sv
